>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RTCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rtca_pkg.sv
// ---------------------------------------------------------------------------
// RTC package
// Types, command codes and register indexes of the real-time clock block.
// ---------------------------------------------------------------------------
package rtca_pkg;

    localparam int TICK_W   = 20;
    localparam int TIME_W   = 64;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = 4;
    localparam int CMD_W    = 2;

    localparam logic [TICK_W-1:0] NS_PER_TICK_RST = TICK_W'(1);

    // Commands.
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Register indexes (byte offset divided by four).
    localparam logic [IDX_W-1:0] REG_TIME_LO   = 4'd0;
    localparam logic [IDX_W-1:0] REG_TIME_HI   = 4'd1;
    localparam logic [IDX_W-1:0] REG_ALARM_LO  = 4'd2;
    localparam logic [IDX_W-1:0] REG_ALARM_HI  = 4'd3;
    localparam logic [IDX_W-1:0] REG_IRQ_EN    = 4'd4;
    localparam logic [IDX_W-1:0] REG_ALARM_CLR = 4'd5;
    localparam logic [IDX_W-1:0] REG_ALARM_STS = 4'd6;
    localparam logic [IDX_W-1:0] REG_IRQ_CLR   = 4'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  register_index;
        logic [WORD_W-1:0] write_data;
    } t_rtca_in;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq_line;
    } t_rtca_out;

endpackage

>>> design/rtca_core.sv
// ---------------------------------------------------------------------------
// RTC core
// Clock state, alarm logic and register decode; one accepted item per cycle.
// ---------------------------------------------------------------------------
module rtca_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  rtca_pkg::t_rtca_in         i_item,
    input  logic                       i_cfg_wr_en,
    input  logic [rtca_pkg::TICK_W-1:0] i_cfg_wr_data,
    output rtca_pkg::t_rtca_out        o_result
);
    import rtca_pkg::*;

    // Visible time and offset are both kept so that no path chains two
    // 64-bit adds: time always equals raw count plus offset.
    logic [TICK_W-1:0] r_ns_per_tick;
    logic [TIME_W-1:0] r_raw, n_raw;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TIME_W-1:0] r_offset, n_offset;
    logic [TIME_W-1:0] r_alarm, n_alarm;
    logic [TIME_W-1:0] r_deadline, n_deadline;
    logic              r_armed, n_armed;
    logic              r_pending, n_pending;
    logic              r_enable, n_enable;
    logic [WORD_W-1:0] rd_data;
    logic [TIME_W-1:0] tick_inc;
    logic [TIME_W-1:0] deadline_gap;
    logic [TIME_W-1:0] arm_alarm;

    assign tick_inc     = {{(TIME_W-TICK_W){1'b0}}, r_ns_per_tick};
    assign deadline_gap = r_deadline - r_raw;
    assign arm_alarm    = {r_alarm[TIME_W-1:WORD_W], i_item.write_data};

    always_comb begin
        n_raw      = r_raw;
        n_time     = r_time;
        n_offset   = r_offset;
        n_alarm    = r_alarm;
        n_deadline = r_deadline;
        n_armed    = r_armed;
        n_pending  = r_pending;
        n_enable   = r_enable;
        rd_data    = '0;
        if (i_accept) begin
            unique case (i_item.command)
                CMD_READ: begin
                    unique case (i_item.register_index)
                        REG_TIME_LO:   rd_data = r_time[WORD_W-1:0];
                        REG_TIME_HI:   rd_data = r_time[TIME_W-1:WORD_W];
                        REG_ALARM_LO:  rd_data = r_alarm[WORD_W-1:0];
                        REG_ALARM_HI:  rd_data = r_alarm[TIME_W-1:WORD_W];
                        REG_IRQ_EN:    rd_data = {{(WORD_W-1){1'b0}}, r_enable};
                        REG_ALARM_STS: rd_data = {{(WORD_W-1){1'b0}}, r_armed};
                        default:       rd_data = '0;
                    endcase
                end
                CMD_WRITE: begin
                    unique case (i_item.register_index)
                        REG_TIME_LO: begin
                            n_time   = {r_time[TIME_W-1:WORD_W], i_item.write_data};
                            n_offset = n_time - r_raw;
                        end
                        REG_TIME_HI: begin
                            n_time   = {i_item.write_data, r_time[WORD_W-1:0]};
                            n_offset = n_time - r_raw;
                        end
                        REG_ALARM_LO: begin
                            n_alarm = arm_alarm;
                            if (arm_alarm <= r_time) begin
                                n_armed   = 1'b0;
                                n_pending = 1'b1;
                            end else begin
                                // raw + (alarm - time) reduces to alarm - offset.
                                n_deadline = arm_alarm - r_offset;
                                n_armed    = 1'b1;
                            end
                        end
                        REG_ALARM_HI: n_alarm = {i_item.write_data, r_alarm[WORD_W-1:0]};
                        REG_IRQ_EN:    n_enable  = i_item.write_data[0];
                        REG_ALARM_CLR: n_armed   = 1'b0;
                        REG_IRQ_CLR:   n_pending = 1'b0;
                        default: ;
                    endcase
                end
                CMD_TICK: begin
                    n_raw  = r_raw + tick_inc;
                    n_time = r_time + tick_inc;
                    if (r_armed && (deadline_gap <= tick_inc)) begin
                        n_armed   = 1'b0;
                        n_pending = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns_per_tick <= NS_PER_TICK_RST;
            r_raw         <= '0;
            r_time        <= '0;
            r_offset      <= '0;
            r_alarm       <= '0;
            r_deadline    <= '0;
            r_armed       <= 1'b0;
            r_pending     <= 1'b0;
            r_enable      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ns_per_tick <= i_cfg_wr_data;
            end
            r_raw      <= n_raw;
            r_time     <= n_time;
            r_offset   <= n_offset;
            r_alarm    <= n_alarm;
            r_deadline <= n_deadline;
            r_armed    <= n_armed;
            r_pending  <= n_pending;
            r_enable   <= n_enable;
        end
    end

    assign o_result.read_data = rd_data;
    assign o_result.irq_line  = n_pending & n_enable;

endmodule

>>> design/rtca_skid.sv
// ---------------------------------------------------------------------------
// RTC result buffer
// Output register with a skid entry so that ready comes from a register.
// ---------------------------------------------------------------------------
module rtca_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rtca_pkg::t_rtca_out i_data,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output rtca_pkg::t_rtca_out o_data
);
    import rtca_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_rtca_out r_out, n_out;
    t_rtca_out r_skid, n_skid;
    logic      out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                // A push cannot happen here: ready is low while the skid is full.
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
                if (i_push) begin
                    n_out = i_data;
                end
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> design/rtc_counter_with_alarm.sv
// ---------------------------------------------------------------------------
// RTC counter with alarm
// 64-bit nanosecond clock with one alarm, driven by register and tick items.
// ---------------------------------------------------------------------------
//
// Channel  | Handshake                  | Payload
// ---------+----------------------------+----------------------------------
// input    | i_in_valid / o_in_ready    | i_in_data  (command, index, data)
// result   | o_out_valid / i_out_ready  | o_out_data (read_data, irq_line)
// config   | i_cfg_wr_en, no wait       | i_cfg_wr_data (ns_per_tick)
//
// Every item is finished at the edge of its transfer: its state update takes
// effect at that edge and its result is registered at that same edge, so items
// may follow back to back, one per cycle while input ready is high. The longest
// path is one 64-bit subtract and compare in the alarm logic. Reset is
// synchronous and active low and leaves the block ready on the next cycle. A
// stalled result waits in the output register while one more item is taken
// into the skid entry; input ready drops only while that skid entry is full.
//
module rtc_counter_with_alarm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rtca_pkg::t_rtca_in          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rtca_pkg::t_rtca_out         o_out_data,
    input  logic                        i_cfg_wr_en,
    input  logic [rtca_pkg::TICK_W-1:0] i_cfg_wr_data
);
    import rtca_pkg::*;

    logic      in_xfer;
    t_rtca_out core_result;

    // An input transfer updates the clock state and produces its result in
    // the same cycle; the result is then held by the buffer below.
    assign in_xfer = i_in_valid && o_in_ready;

    rtca_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_item        (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (core_result)
    );

    // The buffer decouples input ready from output ready, so while a result is
    // stalled the input side takes one more item into the skid entry and then stops.
    rtca_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (core_result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> design/rtca_checker.sv
// ---------------------------------------------------------------------------
// RTC port checker
// Port-level assertions on the clock block, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rtca_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rtca_pkg::t_rtca_out o_out_data
);
    import rtca_pkg::*;

    // Every input transfer is followed by a valid result in the next cycle.
    `RTCA_ASSERT_NXT(a_xfer_gives_result, i_in_valid && o_in_ready, o_out_valid, "no result after transfer")

    // Input ready drops only when a result is being held.
    `RTCA_ASSERT_IMP(a_ready_low_only_held, !o_in_ready, o_out_valid, "ready low with no held result")

    // A stalled result holds its value.
    `RTCA_ASSERT_NXT(a_stall_holds, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")

    // With both sides stalled and ready low, ready stays low.
    `RTCA_ASSERT_NXT(a_full_stays_full, !o_in_ready && !i_out_ready, !o_in_ready, "buffer emptied while stalled")

endmodule

bind rtc_counter_with_alarm rtca_checker u_rtca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
